// ===== src/client_heartbeat_monitor_macros.svh =====
// ---------------------------------------------------------------------------
// client_heartbeat_monitor assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef CLIENT_HEARTBEAT_MONITOR_MACROS_SVH
`define CLIENT_HEARTBEAT_MONITOR_MACROS_SVH

// implication checked every cycle outside reset
`define CHM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("violation");

// implication checked in the next cycle
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("violation");

`endif

// ===== src/chm_pkg.sv =====
// ---------------------------------------------------------------------------
// chm_pkg
// types, codes and defaults shared by the heartbeat monitor
// ---------------------------------------------------------------------------
package chm_pkg;

  localparam int SlotsDefault = 16;

  localparam logic [2:0] CmdTick   = 3'd0;
  localparam logic [2:0] CmdAdd    = 3'd1;
  localparam logic [2:0] CmdReply  = 3'd2;
  localparam logic [2:0] CmdRemId  = 3'd3;
  localparam logic [2:0] CmdRemAdr = 3'd4;

  localparam logic [3:0] EvAdded    = 4'd0;
  localparam logic [3:0] EvDup      = 4'd1;
  localparam logic [3:0] EvFull     = 4'd2;
  localparam logic [3:0] EvReplyOk  = 4'd3;
  localparam logic [3:0] EvReplyIgn = 4'd4;
  localparam logic [3:0] EvProbe    = 4'd5;
  localparam logic [3:0] EvTimeout  = 4'd6;
  localparam logic [3:0] EvRemoved  = 4'd7;
  localparam logic [3:0] EvNotFound = 4'd8;
  localparam logic [3:0] EvTickDone = 4'd9;

  localparam logic [1:0] RegInterval = 2'd0;
  localparam logic [1:0] RegRetries  = 2'd1;
  localparam logic [1:0] RegTimeout  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request, advance clock on tick
    logic clr;    // clear scan index and match flags
    logic scan;   // process slot at scan index
    logic finish; // emit final result
  } chm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } chm_sts_t;

endpackage

// ===== src/chm_ctrl.sv =====
// ---------------------------------------------------------------------------
// chm_ctrl
// sequencer: load, walk every slot, emit final result
// ---------------------------------------------------------------------------
module chm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        command,
  input  chm_pkg::chm_sts_t sts,
  output chm_pkg::chm_cmd_t cmd,
  output logic              busy
);
  import chm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SCAN, ST_DONE} state_t;
  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && command <= CmdRemAdr) begin
            state <= ST_LOAD;
            busy  <= 1'b1;
          end
        end
        ST_LOAD: state <= ST_SCAN;
        ST_SCAN: if (sts.scan_last) state <= ST_DONE;
        ST_DONE: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.load   = (state == ST_IDLE) && start && (command <= CmdRemAdr);
    cmd.clr    = (state == ST_LOAD);
    cmd.scan   = (state == ST_SCAN);
    cmd.finish = (state == ST_DONE);
  end

endmodule

// ===== src/chm_dp.sv =====
// ---------------------------------------------------------------------------
// chm_dp
// slot table, registers and per-slot processing, one slot per cycle
// ---------------------------------------------------------------------------
module chm_dp #(
  parameter int SLOTS = chm_pkg::SlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  chm_pkg::chm_cmd_t cmd,
  output chm_pkg::chm_sts_t sts,
  input  logic [2:0]        command,
  input  logic [15:0]       tick_ms,
  input  logic [31:0]       ip_addr,
  input  logic [15:0]       port_num,
  input  logic [15:0]       client_key,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              result_valid,
  output logic [3:0]        event_res,
  output logic [15:0]       client_key_out,
  output logic [31:0]       ip_out,
  output logic [15:0]       port_out,
  output logic [31:0]       value_out,
  output logic              last
);
  import chm_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0] probe_interval_ms;
  logic [7:0]  max_retries;
  logic [31:0] drop_timeout_ms;
  logic [31:0] server_time;
  logic [15:0] next_key;

  logic [SLOTS-1:0] slot_valid;
  logic [15:0] slot_key        [SLOTS];
  logic [31:0] slot_ip         [SLOTS];
  logic [15:0] slot_port       [SLOTS];
  logic [31:0] slot_last_seen  [SLOTS];
  logic [31:0] slot_probe_time [SLOTS];
  logic        slot_waiting    [SLOTS];
  logic [7:0]  slot_retries    [SLOTS];

  logic [2:0]  r_cmd;
  logic [31:0] r_ip;
  logic [15:0] r_port;
  logic [15:0] r_key;
  logic [IW-1:0] idx;
  logic        found;
  logic [IW-1:0] found_idx;
  logic        free_found;
  logic [IW-1:0] free_idx;
  // probe threshold: interval times (retries + 1), formed for the slot at the scan index
  logic [31:0] elapsed;
  logic [39:0] thresh;
  logic        addr_hit;
  logic        key_hit;
  logic        v;
  logic [7:0]  rt;

  assign sts.scan_last = (idx == IW'(SLOTS - 1));
  assign v        = slot_valid[idx];
  assign rt       = slot_retries[idx];
  assign elapsed  = server_time - slot_last_seen[idx];
  assign thresh   = 40'(probe_interval_ms) * 40'({1'b0, rt} + 9'd1);
  assign addr_hit = v && slot_ip[idx] == r_ip && slot_port[idx] == r_port;
  assign key_hit  = v && slot_key[idx] == r_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_interval_ms <= 16'd1000;
      max_retries       <= 8'd5;
      drop_timeout_ms   <= 32'd10000;
      server_time       <= '0;
      next_key          <= '0;
      slot_valid        <= '0;
      result_valid      <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegInterval: probe_interval_ms <= cfg_data[15:0];
          RegRetries:  max_retries       <= cfg_data[7:0];
          RegTimeout:  drop_timeout_ms   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        r_cmd  <= command;
        r_ip   <= ip_addr;
        r_port <= port_num;
        r_key  <= client_key;
        if (command == CmdTick) server_time <= server_time + 32'(tick_ms);
      end
      if (cmd.clr) begin
        idx        <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.scan) begin
        idx <= idx + 1'b1;
        if (r_cmd == CmdTick) begin
          if (v && elapsed >= 32'(probe_interval_ms)) begin
            if (elapsed >= drop_timeout_ms || rt > max_retries) begin
              slot_valid[idx] <= 1'b0;
              result_valid    <= 1'b1;
              event_res       <= EvTimeout;
              client_key_out  <= slot_key[idx];
              ip_out          <= slot_ip[idx];
              port_out        <= slot_port[idx];
              value_out       <= '0;
              last            <= 1'b0;
            end else if (!slot_waiting[idx] || {8'd0, elapsed} >= thresh) begin
              result_valid    <= 1'b1;
              event_res       <= EvProbe;
              client_key_out  <= slot_key[idx];
              ip_out          <= slot_ip[idx];
              port_out        <= slot_port[idx];
              value_out       <= server_time;
              last            <= 1'b0;
              if (rt == 8'd0) slot_probe_time[idx] <= server_time;
              slot_waiting[idx] <= 1'b1;
              if (rt != 8'hFF) slot_retries[idx] <= rt + 8'd1;
            end
          end
        end else begin
          if (!found && ((r_cmd == CmdRemId) ? key_hit : addr_hit)) begin
            found     <= 1'b1;
            found_idx <= idx;
          end
          if (!free_found && !v) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
        end
      end
      if (cmd.finish) begin
        result_valid   <= 1'b1;
        last           <= 1'b1;
        value_out      <= '0;
        ip_out         <= r_ip;
        port_out       <= r_port;
        client_key_out <= found ? slot_key[found_idx] : 16'd0;
        unique case (r_cmd)
          CmdTick: begin
            event_res      <= EvTickDone;
            ip_out         <= '0;
            port_out       <= '0;
          end
          CmdAdd: begin
            if (found) event_res <= EvDup;
            else if (!free_found) event_res <= EvFull;
            else begin
              event_res                 <= EvAdded;
              client_key_out            <= next_key;
              slot_valid[free_idx]      <= 1'b1;
              slot_key[free_idx]        <= next_key;
              slot_ip[free_idx]         <= r_ip;
              slot_port[free_idx]       <= r_port;
              slot_last_seen[free_idx]  <= server_time;
              slot_probe_time[free_idx] <= server_time;
              slot_waiting[free_idx]    <= 1'b0;
              slot_retries[free_idx]    <= '0;
              next_key                  <= next_key + 16'd1;
            end
          end
          CmdReply: begin
            if (!found) event_res <= EvNotFound;
            else if (!slot_waiting[found_idx]) event_res <= EvReplyIgn;
            else begin
              event_res                 <= EvReplyOk;
              value_out                 <= server_time - slot_probe_time[found_idx];
              slot_last_seen[found_idx] <= server_time;
              slot_waiting[found_idx]   <= 1'b0;
              slot_retries[found_idx]   <= '0;
            end
          end
          CmdRemId: begin
            if (found) begin
              event_res             <= EvRemoved;
              ip_out                <= slot_ip[found_idx];
              port_out              <= slot_port[found_idx];
              slot_valid[found_idx] <= 1'b0;
            end else begin
              event_res      <= EvNotFound;
              client_key_out <= r_key;
              ip_out         <= '0;
              port_out       <= '0;
            end
          end
          default: begin
            if (found) begin
              event_res             <= EvRemoved;
              slot_valid[found_idx] <= 1'b0;
            end else event_res <= EvNotFound;
          end
        endcase
      end
    end
  end

endmodule

// ===== src/client_heartbeat_monitor.sv =====
// ---------------------------------------------------------------------------
// client_heartbeat_monitor
// keepalive supervision of a table of client slots
// ---------------------------------------------------------------------------
// Busy rises on the accepting edge and stays high while the controller sets up
// the scan, walks the table slot by slot with the single compare unit, and
// forms the final result. The final result is strobed in the same cycle that
// busy falls, and the next request can be accepted in that same cycle. Results
// appear one per cycle with strobe high and must be taken when shown. Codes 5
// to 7 are dropped without results or a busy period.
module client_heartbeat_monitor #(
  parameter int SLOTS = chm_pkg::SlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [15:0] tick_ms,
  input  logic [31:0] ip_addr,
  input  logic [15:0] port_num,
  input  logic [15:0] client_key,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [3:0]  event_res,
  output logic [15:0] client_key_out,
  output logic [31:0] ip_out,
  output logic [15:0] port_out,
  output logic [31:0] value_out,
  output logic        last
);
  import chm_pkg::*;

  chm_cmd_t cmd;
  chm_sts_t sts;

  assign cfg_ready = 1'b1;

  chm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  chm_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .command(command), .tick_ms(tick_ms), .ip_addr(ip_addr),
    .port_num(port_num), .client_key(client_key),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(strobe), .event_res(event_res),
    .client_key_out(client_key_out), .ip_out(ip_out), .port_out(port_out),
    .value_out(value_out), .last(last)
  );

endmodule

// ===== src/chm_checker.sv =====
// ---------------------------------------------------------------------------
// chm_checker
// port-level checks of the heartbeat monitor
// ---------------------------------------------------------------------------
`include "client_heartbeat_monitor_macros.svh"

module chm_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] command,
  input logic       strobe,
  input logic [3:0] event_res,
  input logic       last
);
  import chm_pkg::*;

  `CHM_ASSERT_IMP(a_no_strobe_idle, clk, rst, !busy && !$past(busy), !strobe)
  `CHM_ASSERT_IMP(a_last_ends_busy, clk, rst, strobe && last, $fell(busy))
  `CHM_ASSERT_IMP(a_done_is_last, clk, rst, strobe && event_res == EvTickDone, last)
  `CHM_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy && command <= CmdRemAdr, busy)
endmodule

bind client_heartbeat_monitor chm_checker u_chm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
  .strobe(strobe), .event_res(event_res), .last(last)
);
